// File: rtl/mau_pkg.sv
// mau_pkg: shared constants for the modular arithmetic unit.
// Used by mau_mulmod, modular_arithmetic_unit and mau_checker; no dependencies.
package mau_pkg;

    localparam int VALUE_BITS_DEF = 31;
    localparam int DATA_W         = 31;
    localparam int REQ_W          = 3;

    localparam logic [DATA_W-1:0] MODULUS_RESET = 31'd1000000007;

    localparam logic [REQ_W-1:0] OP_NEG = 3'd0;
    localparam logic [REQ_W-1:0] OP_ADD = 3'd1;
    localparam logic [REQ_W-1:0] OP_SUB = 3'd2;
    localparam logic [REQ_W-1:0] OP_MUL = 3'd3;
    localparam logic [REQ_W-1:0] OP_INV = 3'd4;
    localparam logic [REQ_W-1:0] OP_DIV = 3'd5;

endpackage

// File: rtl/mau_mulmod.sv
// mau_mulmod: bit-serial interleaved modular multiplier, one bit of y per cycle.
// Computes (x * y) mod m for x < m. Depends on mau_pkg.
module mau_mulmod #(
    parameter int VALUE_BITS = mau_pkg::VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] x,
    input  logic [VALUE_BITS-1:0] y,
    input  logic [VALUE_BITS-1:0] m,
    output logic                  done,
    output logic [VALUE_BITS-1:0] prod
);

    localparam int CW = $clog2(VALUE_BITS);
    localparam int TW = VALUE_BITS + 2;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic [VALUE_BITS-1:0] x_reg, x_next;
    logic [VALUE_BITS-1:0] y_reg, y_next;

    logic [TW-1:0] t;
    logic [TW-1:0] m1;
    logic [TW-1:0] m2;
    logic [TW-1:0] d1;
    logic [TW-1:0] d2;

    always_comb
    begin
        m1 = {2'b00, m};
        m2 = {1'b0, m, 1'b0};
        t  = {1'b0, acc_reg, 1'b0} + (y_reg[VALUE_BITS-1] ? {2'b00, x_reg} : '0);
        d1 = t - m1;
        d2 = t - m2;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(VALUE_BITS - 1);
            acc_next  = '0;
            x_next    = x;
            y_next    = y;
        end
        else if (busy_reg)
        begin
            if (t >= m2)
            begin
                acc_next = d2[VALUE_BITS-1:0];
            end
            else if (t >= m1)
            begin
                acc_next = d1[VALUE_BITS-1:0];
            end
            else
            begin
                acc_next = t[VALUE_BITS-1:0];
            end
            y_next = {y_reg[VALUE_BITS-2:0], 1'b0};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// File: rtl/modular_arithmetic_unit.sv
// modular_arithmetic_unit: top level, modulus register and operation sequencer.
// Instantiates mau_mulmod; depends on mau_pkg.
//
// A transaction is taken at a rising edge where start is high and busy is low. Busy
// then stays high until the single result appears on result/status with done high for
// one cycle. The receiver cannot stall: it must take the result in that cycle. Busy is
// already low in the done cycle, so the next transaction can be taken there. Every
// product, every operand reduction and every step of the Fermat power runs through the
// one bit-serial modular multiplier. Negate, add and subtract take two reduction
// passes; multiply takes three passes; a zero residue for inverse or divide is flagged
// after the two reduction passes. Otherwise inverse takes one squaring pass for each
// bit of the exponent (modulus - 2) and one more pass for each set bit; divide adds
// one pass. Selector codes 6 and 7 return 0 without a multiplier pass. Modulus register
// values 0 and 1 act as modulus 1; the modulus may only be written while busy is low.
module modular_arithmetic_unit #(
    parameter int VALUE_BITS = mau_pkg::VALUE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [mau_pkg::REQ_W-1:0]    req_type,
    input  logic [mau_pkg::DATA_W-1:0]   operand_a,
    input  logic [mau_pkg::DATA_W-1:0]   operand_b,
    output logic                         done,
    output logic [mau_pkg::DATA_W-1:0]   result,
    output logic                         status,
    input  logic                         cfg_wr_en,
    input  logic [mau_pkg::DATA_W-1:0]   cfg_wr_data
);

    localparam int W = VALUE_BITS;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_RED_A    = 4'd1;
    localparam logic [3:0] ST_RED_B    = 4'd2;
    localparam logic [3:0] ST_DISPATCH = 4'd3;
    localparam logic [3:0] ST_POW_INIT = 4'd4;
    localparam logic [3:0] ST_POW_STEP = 4'd5;
    localparam logic [3:0] ST_POW_ACC  = 4'd6;
    localparam logic [3:0] ST_POW_SQR  = 4'd7;
    localparam logic [3:0] ST_MUL_WAIT = 4'd8;

    logic [3:0]                state_reg, state_next;
    logic [W-1:0]              mod_reg, mod_next;
    logic [mau_pkg::REQ_W-1:0] op_reg, op_next;
    logic [W-1:0]              a_reg, a_next;
    logic [W-1:0]              b_reg, b_next;
    logic [W-1:0]              acc_reg, acc_next;
    logic [W-1:0]              base_reg, base_next;
    logic [W-1:0]              exp_reg, exp_next;
    logic [W-1:0]              res_reg, res_next;
    logic                      st_reg, st_next;
    logic                      done_reg, done_next;
    logic                      mm_start_reg, mm_start_next;
    logic [W-1:0]              mm_x_reg, mm_x_next;
    logic [W-1:0]              mm_y_reg, mm_y_next;

    logic         mm_done;
    logic [W-1:0] mm_prod;
    logic         mod_small;
    logic [W-1:0] m_eff;
    logic [W-1:0] one_res;
    logic [W:0]   sum;
    logic [W:0]   sum_red;
    logic [W:0]   diff_wrap;

    assign mod_small = (mod_reg < W'(2));
    assign m_eff     = mod_small ? W'(1) : mod_reg;
    assign one_res   = mod_small ? '0 : W'(1);

    assign sum       = {1'b0, a_reg} + {1'b0, b_reg};
    assign sum_red   = sum - {1'b0, m_eff};
    assign diff_wrap = {1'b0, a_reg} + {1'b0, m_eff} - {1'b0, b_reg};

    mau_mulmod #(
        .VALUE_BITS(VALUE_BITS)
    ) u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm_start_reg),
        .x     (mm_x_reg),
        .y     (mm_y_reg),
        .m     (m_eff),
        .done  (mm_done),
        .prod  (mm_prod)
    );

    always_comb
    begin
        mod_next = mod_reg;
        if (cfg_wr_en)
        begin
            mod_next = cfg_wr_data[W-1:0];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        acc_next      = acc_reg;
        base_next     = base_reg;
        exp_next      = exp_reg;
        res_next      = res_reg;
        st_next       = st_reg;
        done_next     = 1'b0;
        mm_start_next = 1'b0;
        mm_x_next     = mm_x_reg;
        mm_y_next     = mm_y_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next = req_type;
                    a_next  = operand_a[W-1:0];
                    b_next  = operand_b[W-1:0];
                    if (req_type > mau_pkg::OP_DIV)
                    begin
                        state_next = ST_DISPATCH;
                    end
                    else
                    begin
                        mm_start_next = 1'b1;
                        mm_x_next     = one_res;
                        mm_y_next     = operand_a[W-1:0];
                        state_next    = ST_RED_A;
                    end
                end
            end
            ST_RED_A:
            begin
                if (mm_done)
                begin
                    a_next        = mm_prod;
                    mm_start_next = 1'b1;
                    mm_x_next     = one_res;
                    mm_y_next     = b_reg;
                    state_next    = ST_RED_B;
                end
            end
            ST_RED_B:
            begin
                if (mm_done)
                begin
                    b_next     = mm_prod;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                st_next    = 1'b0;
                res_next   = '0;
                state_next = ST_IDLE;
                done_next  = 1'b1;
                case (op_reg)
                    mau_pkg::OP_NEG:
                    begin
                        res_next = (a_reg == '0) ? '0 : m_eff - a_reg;
                    end
                    mau_pkg::OP_ADD:
                    begin
                        res_next = (sum >= {1'b0, m_eff}) ? sum_red[W-1:0] : sum[W-1:0];
                    end
                    mau_pkg::OP_SUB:
                    begin
                        res_next = (a_reg >= b_reg) ? a_reg - b_reg : diff_wrap[W-1:0];
                    end
                    mau_pkg::OP_MUL:
                    begin
                        done_next     = 1'b0;
                        mm_start_next = 1'b1;
                        mm_x_next     = a_reg;
                        mm_y_next     = b_reg;
                        state_next    = ST_MUL_WAIT;
                    end
                    mau_pkg::OP_INV:
                    begin
                        if (a_reg == '0)
                        begin
                            st_next = 1'b1;
                        end
                        else
                        begin
                            done_next  = 1'b0;
                            base_next  = a_reg;
                            state_next = ST_POW_INIT;
                        end
                    end
                    mau_pkg::OP_DIV:
                    begin
                        if (b_reg == '0)
                        begin
                            st_next = 1'b1;
                        end
                        else
                        begin
                            done_next  = 1'b0;
                            base_next  = b_reg;
                            state_next = ST_POW_INIT;
                        end
                    end
                    default:
                    begin
                        res_next = '0;
                    end
                endcase
            end
            ST_POW_INIT:
            begin
                acc_next   = W'(1);
                exp_next   = m_eff - W'(2);
                state_next = ST_POW_STEP;
            end
            ST_POW_STEP:
            begin
                if (exp_reg == '0)
                begin
                    if (op_reg == mau_pkg::OP_INV)
                    begin
                        res_next   = acc_reg;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        mm_start_next = 1'b1;
                        mm_x_next     = a_reg;
                        mm_y_next     = acc_reg;
                        state_next    = ST_MUL_WAIT;
                    end
                end
                else if (exp_reg[0])
                begin
                    mm_start_next = 1'b1;
                    mm_x_next     = acc_reg;
                    mm_y_next     = base_reg;
                    state_next    = ST_POW_ACC;
                end
                else
                begin
                    mm_start_next = 1'b1;
                    mm_x_next     = base_reg;
                    mm_y_next     = base_reg;
                    state_next    = ST_POW_SQR;
                end
            end
            ST_POW_ACC:
            begin
                if (mm_done)
                begin
                    acc_next      = mm_prod;
                    mm_start_next = 1'b1;
                    mm_x_next     = base_reg;
                    mm_y_next     = base_reg;
                    state_next    = ST_POW_SQR;
                end
            end
            ST_POW_SQR:
            begin
                if (mm_done)
                begin
                    base_next  = mm_prod;
                    exp_next   = {1'b0, exp_reg[W-1:1]};
                    state_next = ST_POW_STEP;
                end
            end
            ST_MUL_WAIT:
            begin
                if (mm_done)
                begin
                    res_next   = mm_prod;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mod_reg      <= mau_pkg::MODULUS_RESET[W-1:0];
            done_reg     <= 1'b0;
            mm_start_reg <= 1'b0;
            st_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            mod_reg      <= mod_next;
            done_reg     <= done_next;
            mm_start_reg <= mm_start_next;
            st_reg       <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        acc_reg  <= acc_next;
        base_reg <= base_next;
        exp_reg  <= exp_next;
        res_reg  <= res_next;
        mm_x_reg <= mm_x_next;
        mm_y_reg <= mm_y_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = mau_pkg::DATA_W'(res_reg);
    assign status = st_reg;

endmodule

// File: rtl/mau_checker.sv
// mau_checker: port-level assertions for modular_arithmetic_unit, bound to the top.
// Depends on mau_pkg and modular_arithmetic_unit.
module mau_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic [mau_pkg::DATA_W-1:0] result,
    input logic                       status
);

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_done_fall: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $fell(busy))
        else $error("result without a finished transaction");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (result == '0))
        else $error("error result not zero");

endmodule

bind modular_arithmetic_unit mau_checker u_mau_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result),
    .status (status)
);

// File: bench/mau_checker.sv
// mau_tb_checker: watches the request, result and modulus-write ports of the modular
// arithmetic unit, predicts every result and compares it with what the unit returns.
// Depends on mau_pkg; instantiated beside the unit by modular_arithmetic_unit_tb.
module mau_tb_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [mau_pkg::REQ_W-1:0]    req_type,
    input  logic [mau_pkg::DATA_W-1:0]   operand_a,
    input  logic [mau_pkg::DATA_W-1:0]   operand_b,
    input  logic                         done,
    input  logic [mau_pkg::DATA_W-1:0]   result,
    input  logic                         status,
    input  logic                         cfg_wr_en,
    input  logic [mau_pkg::DATA_W-1:0]   cfg_wr_data,
    output int unsigned                  fail_count,
    output int unsigned                  pending_count,
    output int unsigned                  checked_count,
    output int unsigned                  flagged_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W = mau_pkg::DATA_W;
    localparam int REQ_W  = mau_pkg::REQ_W;

    typedef struct packed {
        logic [DATA_W-1:0] residue;
        logic              zero_inv;
    } residue_result_t;

    residue_result_t   expected_q[$];
    residue_result_t   want;
    logic [DATA_W-1:0] modulus_copy = mau_pkg::MODULUS_RESET;
    int unsigned       failures = 0;
    int unsigned       checked = 0;
    int unsigned       flagged = 0;

    function automatic longint unsigned power_mod(longint unsigned base,
                                                  longint unsigned exponent,
                                                  longint unsigned m);
        longint unsigned acc;
        longint unsigned sq;
        longint unsigned e;
        acc = 64'd1 % m;
        sq  = base % m;
        e   = exponent;
        while (e != 64'd0)
        begin
            if (e[0])
                acc = (acc * sq) % m;
            sq = (sq * sq) % m;
            e  = e >> 1;
        end
        return acc;
    endfunction

    function automatic residue_result_t predict_residue(logic [REQ_W-1:0]  op,
                                                        logic [DATA_W-1:0] a_raw,
                                                        logic [DATA_W-1:0] b_raw,
                                                        logic [DATA_W-1:0] mod_reg);
        longint unsigned m;
        longint unsigned a;
        longint unsigned b;
        longint unsigned r;
        residue_result_t res;
        m = 64'(mod_reg);
        // register values 0 and 1 behave as modulus 1
        if (m < 64'd2)
            m = 64'd1;
        a = 64'(a_raw) % m;
        b = 64'(b_raw) % m;
        r = 64'd0;
        res.zero_inv = 1'b0;
        case (op)
            mau_pkg::OP_NEG: r = (m - a) % m;
            mau_pkg::OP_ADD: r = (a + b) % m;
            mau_pkg::OP_SUB: r = (a + m - b) % m;
            mau_pkg::OP_MUL: r = (a * b) % m;
            mau_pkg::OP_INV:
            begin
                if (a == 64'd0)
                    res.zero_inv = 1'b1;
                else
                    r = power_mod(a, m - 64'd2, m);
            end
            mau_pkg::OP_DIV:
            begin
                if (b == 64'd0)
                    res.zero_inv = 1'b1;
                else
                    r = (a * power_mod(b, m - 64'd2, m)) % m;
            end
            default: r = 64'd0;
        endcase
        res.residue = r[DATA_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_copy = mau_pkg::MODULUS_RESET;
            expected_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    failures++;
                    $display("%0t: result with no transaction outstanding: result %0d status %0d",
                             $time, result, status);
                end
                else
                begin
                    want = expected_q.pop_front();
                    checked++;
                    if (want.zero_inv)
                        flagged++;
                    if (result !== want.residue || status !== want.zero_inv)
                    begin
                        failures++;
                        $display("%0t: mismatch: expected result %0d status %0d, got result %0d status %0d",
                                 $time, want.residue, want.zero_inv, result, status);
                    end
                end
            end
            if (start && !busy)
                expected_q = {expected_q, predict_residue(req_type, operand_a, operand_b,
                                                          modulus_copy)};
            if (cfg_wr_en)
                modulus_copy = cfg_wr_data;
        end
        fail_count    <= failures;
        pending_count <= expected_q.size();
        checked_count <= checked;
        flagged_count <= flagged;
    end

endmodule

// File: bench/modular_arithmetic_unit_tb.sv
// modular_arithmetic_unit_tb: drives directed and random transactions into the modular
// arithmetic unit across a range of modulus settings and idle patterns.
// Depends on mau_pkg, modular_arithmetic_unit and mau_tb_checker, which does the checking.
module modular_arithmetic_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W = mau_pkg::DATA_W;
    localparam int REQ_W  = mau_pkg::REQ_W;

    localparam int          CLK_PERIOD  = 8;
    localparam int unsigned CYCLE_LIMIT = 15_000_000;
    localparam int          TAIL_CYCLES = 40;

    localparam logic [DATA_W-1:0] VALUE_MAX   = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0] MOD_RESET   = mau_pkg::MODULUS_RESET;
    localparam logic [REQ_W-1:0]  OP_SPARE_LO = 3'd6;
    localparam logic [REQ_W-1:0]  OP_SPARE_HI = 3'd7;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic [REQ_W-1:0]  req_type = '0;
    logic [DATA_W-1:0] operand_a = '0;
    logic [DATA_W-1:0] operand_b = '0;
    logic              cfg_wr_en = 1'b0;
    logic [DATA_W-1:0] cfg_wr_data = '0;
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] result;
    logic              status;

    int unsigned fail_count;
    int unsigned pending_count;
    int unsigned checked_count;
    int unsigned flagged_count;

    logic [DATA_W-1:0] cur_mod = MOD_RESET;
    int unsigned       idle_pct = 0;
    int unsigned       phase_count = 0;
    int unsigned       cycle_count = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    modular_arithmetic_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .operand_a  (operand_a),
        .operand_b  (operand_b),
        .done       (done),
        .result     (result),
        .status     (status),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    mau_tb_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .done         (done),
        .result       (result),
        .status       (status),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .fail_count   (fail_count),
        .pending_count(pending_count),
        .checked_count(checked_count),
        .flagged_count(flagged_count)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still outstanding", $time, pending_count);
            $display("modular_arithmetic_unit_tb NOT OK");
            $finish;
        end
    end

    function automatic logic [REQ_W-1:0] pick_op();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 17)
            return mau_pkg::OP_NEG;
        if (roll < 34)
            return mau_pkg::OP_ADD;
        if (roll < 51)
            return mau_pkg::OP_SUB;
        if (roll < 70)
            return mau_pkg::OP_MUL;
        if (roll < 80)
            return mau_pkg::OP_INV;
        if (roll < 92)
            return mau_pkg::OP_DIV;
        if (roll < 96)
            return OP_SPARE_LO;
        return OP_SPARE_HI;
    endfunction

    // biased towards zero residues, the modulus boundary and the top of the range
    function automatic logic [DATA_W-1:0] pick_operand(logic [DATA_W-1:0] m);
        int unsigned sel;
        sel = $urandom_range(0, 11);
        case (sel)
            0:       return '0;
            1:       return VALUE_MAX;
            2:       return m;
            3:       return m - 31'd1;
            4:       return m + 31'd1;
            5:       return DATA_W'($urandom_range(0, 15));
            6:       return DATA_W'(64'(m) * 64'($urandom_range(2, 5)));
            default: return DATA_W'($urandom);
        endcase
    endfunction

    task automatic issue_request(input logic [REQ_W-1:0]  op,
                                 input logic [DATA_W-1:0] a,
                                 input logic [DATA_W-1:0] b);
        bit accepted;
        accepted  = 1'b0;
        req_type  <= op;
        operand_a <= a;
        operand_b <= b;
        start     <= ($urandom_range(0, 99) >= idle_pct);
        while (!accepted)
        begin
            @(posedge clk);
            if (start && !busy)
                accepted = 1'b1;
            else
                start <= ($urandom_range(0, 99) >= idle_pct);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0 || busy)
            @(posedge clk);
    endtask

    task automatic random_requests(input int n);
        for (int i = 0; i < n; i++)
            issue_request(pick_op(), pick_operand(cur_mod), pick_operand(cur_mod));
    endtask

    task automatic run_phase(input logic [DATA_W-1:0] m, input int n, input int unsigned idle);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_mod   = m;
        idle_pct  = idle;
        phase_count++;
        random_requests(n);
        drain_results();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed set under the reset modulus
        phase_count = 1;
        idle_pct    = 0;
        issue_request(mau_pkg::OP_NEG, '0, '0);
        issue_request(mau_pkg::OP_NEG, MOD_RESET, '0);
        issue_request(mau_pkg::OP_NEG, VALUE_MAX, VALUE_MAX);
        issue_request(mau_pkg::OP_ADD, VALUE_MAX, VALUE_MAX);
        issue_request(mau_pkg::OP_ADD, MOD_RESET - 31'd1, 31'd1);
        issue_request(mau_pkg::OP_SUB, '0, 31'd1);
        issue_request(mau_pkg::OP_SUB, 31'd5, 31'd5);
        issue_request(mau_pkg::OP_SUB, VALUE_MAX, '0);
        issue_request(mau_pkg::OP_MUL, MOD_RESET - 31'd1, MOD_RESET - 31'd1);
        issue_request(mau_pkg::OP_MUL, VALUE_MAX, VALUE_MAX);
        issue_request(mau_pkg::OP_MUL, '0, VALUE_MAX);
        issue_request(mau_pkg::OP_INV, '0, VALUE_MAX);
        issue_request(mau_pkg::OP_INV, MOD_RESET, '0);
        issue_request(mau_pkg::OP_INV, 31'd1, '0);
        issue_request(mau_pkg::OP_INV, 31'd2, VALUE_MAX);
        issue_request(mau_pkg::OP_INV, VALUE_MAX, '0);
        issue_request(mau_pkg::OP_DIV, VALUE_MAX, '0);
        issue_request(mau_pkg::OP_DIV, 31'd7, MOD_RESET);
        issue_request(mau_pkg::OP_DIV, '0, 31'd3);
        issue_request(mau_pkg::OP_DIV, VALUE_MAX, VALUE_MAX);
        issue_request(OP_SPARE_LO, VALUE_MAX, VALUE_MAX);
        issue_request(OP_SPARE_HI, 31'd12345, 31'd678);
        random_requests(280);
        drain_results();

        run_phase(VALUE_MAX, 280, 80);
        run_phase(31'd2, 100, 13);
        run_phase(31'd0, 40, 0);
        run_phase(31'd1, 40, 80);
        run_phase(31'd7, 150, 13);
        run_phase(31'd1000000009, 280, 0);
        run_phase(31'd1000, 100, 80);
        run_phase(31'd65537, 150, 13);
        run_phase(DATA_W'($urandom_range(2, 32'h7FFFFFFF)), 200, 80);
        run_phase(MOD_RESET, 230, 13);

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d results over %0d modulus settings, every operation and spare selector;",
                 checked_count, phase_count);
        $display("%0d of them were zero-residue inversions flagged with error status.",
                 flagged_count);
        if (fail_count == 0 && pending_count == 0)
            $display("modular_arithmetic_unit_tb OK");
        else
            $display("modular_arithmetic_unit_tb NOT OK");
        $finish;
    end

endmodule
